// ===== hdl/abmd_pkg.sv =====
// Shared types, widths and helpers for the accelerometer batch motion detector.
// No dependencies; the top level, the divider and the testbench import this package.
package abmd_pkg;

    localparam int BATCH_MAX   = 32;
    localparam int AXES        = 3;
    localparam int AXIS_W      = 13;
    localparam int AXIS_OFFSET = 4000;
    localparam int AXIS_TOP    = (1 << (AXIS_W - 1)) - 1 + AXIS_OFFSET;
    localparam int ADDR_W      = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int CNT_W       = $clog2(BATCH_MAX + 1);
    localparam int SUM_W       = $clog2(BATCH_MAX * AXIS_TOP + 1);
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int SHAKE_W     = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [0:0]        REG_THRESH   = 1'b0;
    localparam logic [AXIS_W-1:0] THRESH_RESET = AXIS_W'(1000);

    typedef logic [AXES-1:0][AXIS_W-1:0] t_axes;
    typedef logic [AXES-1:0][SUM_W-1:0]  t_sums;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    function automatic logic [AXIS_W-1:0] offset_axis(input logic [AXIS_W-1:0] raw);
        logic signed [AXIS_W:0] v;
        v = $signed({raw[AXIS_W-1], raw}) + $signed((AXIS_W + 1)'(AXIS_OFFSET));
        return v[AXIS_W] ? '0 : v[AXIS_W-1:0];
    endfunction

endpackage

// ===== hdl/accel_batch_motion_detector.sv =====
// Top level: sample intake, batch store, mean division, rescan and running totals.
// Depends on abmd_pkg, abmd_ram and abmd_div.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  sample in | start & !busy          | i_accel_x/y/z, i_vibrated, i_last_sample,
//            |                        | i_restart
//  result    | o_valid, one cycle     | o_batch_deviation, o_running_max,
//            |                        | o_shake_total, o_discarded
//  config    | psel & penable & pwrite| paddr, pwdata; prdata, pready
//
// A sample without the last flag leaves busy low; a new one may follow at once.
// A closing sample holds busy through the close state, the divide, a scan of the
// stored samples through the store's read port and the update state.
// A discarded batch holds busy for one cycle only. The result strobe rises in the
// cycle in which busy falls and cannot be stalled. Reset is synchronous and clears
// all totals.
module accel_batch_motion_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [abmd_pkg::AXIS_W-1:0]   i_accel_x,
    input  logic [abmd_pkg::AXIS_W-1:0]   i_accel_y,
    input  logic [abmd_pkg::AXIS_W-1:0]   i_accel_z,
    input  logic                          i_vibrated,
    input  logic                          i_last_sample,
    input  logic                          i_restart,
    output logic                          o_valid,
    output logic [abmd_pkg::AXIS_W-1:0]   o_batch_deviation,
    output logic [abmd_pkg::AXIS_W-1:0]   o_running_max,
    output logic [abmd_pkg::SHAKE_W-1:0]  o_shake_total,
    output logic                          o_discarded,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [abmd_pkg::APB_AW-1:0]   paddr,
    input  logic [abmd_pkg::APB_DW-1:0]   pwdata,
    output logic [abmd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import abmd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_DIV,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state               r_state;
    logic [AXIS_W-1:0]    r_thresh;
    t_sums                r_sums;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_vib;
    logic [AXIS_W-1:0]    r_max;
    logic [SHAKE_W-1:0]   r_shakes;
    logic [ADDR_W-1:0]    r_idx;
    logic                 r_last_rd;
    logic                 r_pend;
    logic [AXIS_W-1:0]    r_big;
    logic                 r_valid;
    logic [AXIS_W-1:0]    r_o_dev;
    logic [AXIS_W-1:0]    r_o_max;
    logic [SHAKE_W-1:0]   r_o_shk;
    logic                 r_o_disc;

    logic                 accept;
    logic                 store_we;
    logic                 discard;
    logic                 rd_en;
    t_axes                sample;
    t_axes                rd_data;
    t_sums                n_sums;
    t_sums                quot;
    t_div_req             div_req;
    logic                 div_done;
    logic [AXIS_W-1:0]    n_big;
    logic [AXIS_W-1:0]    n_max;
    logic [SHAKE_W-1:0]   n_shakes;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign store_we = accept && (r_cnt < CNT_W'(BATCH_MAX));
    assign discard  = r_vib || (r_cnt == '0);

    assign sample[0] = offset_axis(i_accel_x);
    assign sample[1] = offset_axis(i_accel_y);
    assign sample[2] = offset_axis(i_accel_z);

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sums[a] = r_sums[a] + SUM_W'(sample[a]);
        end
    end

    assign rd_en = (r_state == S_SCAN) && !r_last_rd;

    abmd_ram #(
        .WIDTH (AXES * AXIS_W),
        .DEPTH (BATCH_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (sample),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign div_req.start   = (r_state == S_CLOSE) && !discard;
    assign div_req.divisor = r_cnt;

    abmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_sums),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    always_comb begin
        logic [AXIS_W-1:0] s;
        logic [AXIS_W-1:0] m;
        logic [AXIS_W-1:0] d;
        n_big = r_big;
        for (int a = 0; a < AXES; a++) begin
            s = rd_data[a];
            m = quot[a][AXIS_W-1:0];
            d = (s < m) ? m - s : s - m;
            if (d > n_big) begin
                n_big = d;
            end
        end
    end

    assign n_max    = (r_big > r_max) ? r_big : r_max;
    assign n_shakes = ((r_big > r_thresh) && (r_shakes != '1)) ? r_shakes + 1'b1 : r_shakes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_thresh  <= THRESH_RESET;
            r_sums    <= '0;
            r_cnt     <= '0;
            r_vib     <= 1'b0;
            r_max     <= '0;
            r_shakes  <= '0;
            r_idx     <= '0;
            r_last_rd <= 1'b0;
            r_pend    <= 1'b0;
            r_big     <= '0;
            r_valid   <= 1'b0;
            r_o_dev   <= '0;
            r_o_max   <= '0;
            r_o_shk   <= '0;
            r_o_disc  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (psel && penable && pwrite && (paddr[APB_AW-1] == REG_THRESH)) begin
                r_thresh <= pwdata[AXIS_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_restart) begin
                            r_max    <= '0;
                            r_shakes <= '0;
                        end
                        if (i_vibrated) begin
                            r_vib <= 1'b1;
                        end
                        if (store_we) begin
                            r_sums <= n_sums;
                            r_cnt  <= r_cnt + 1'b1;
                        end
                        if (i_last_sample) begin
                            r_state <= S_CLOSE;
                        end
                    end
                end
                S_CLOSE: begin
                    if (discard) begin
                        r_valid  <= 1'b1;
                        r_o_dev  <= '0;
                        r_o_max  <= r_max;
                        r_o_shk  <= r_shakes;
                        r_o_disc <= 1'b1;
                        r_sums   <= '0;
                        r_cnt    <= '0;
                        r_vib    <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_idx     <= '0;
                        r_last_rd <= 1'b0;
                        r_pend    <= 1'b0;
                        r_big     <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        if (r_idx == ADDR_W'(r_cnt - 1'b1)) begin
                            r_last_rd <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_pend) begin
                        r_big <= n_big;
                        if (r_last_rd) begin
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE: begin
                    r_max    <= n_max;
                    r_shakes <= n_shakes;
                    r_valid  <= 1'b1;
                    r_o_dev  <= r_big;
                    r_o_max  <= n_max;
                    r_o_shk  <= n_shakes;
                    r_o_disc <= 1'b0;
                    r_sums   <= '0;
                    r_cnt    <= '0;
                    r_vib    <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_valid;
    assign o_batch_deviation = r_o_dev;
    assign o_running_max     = r_o_max;
    assign o_shake_total     = r_o_shk;
    assign o_discarded       = r_o_disc;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_THRESH) ? APB_DW'(r_thresh) : '0;

endmodule

// ===== hdl/abmd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module abmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/abmd_div.sv =====
// Restoring divider, one quotient bit per cycle, all axis sums in lockstep.
// Depends on abmd_pkg.
module abmd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  abmd_pkg::t_div_req i_req,
    input  abmd_pkg::t_sums   i_dividend,
    output logic              o_done,
    output abmd_pkg::t_sums   o_quotient
);
    import abmd_pkg::*;

    logic                               r_run;
    logic                               r_done;
    logic [STEP_W-1:0]                  r_step;
    logic [CNT_W-1:0]                   r_div;
    t_sums                              r_work;
    logic [AXES-1:0][CNT_W-1:0]         r_rem;
    t_sums                              n_work;
    logic [AXES-1:0][CNT_W-1:0]         n_rem;

    always_comb begin
        logic [CNT_W:0] t;
        for (int a = 0; a < AXES; a++) begin
            t = {r_rem[a], r_work[a][SUM_W-1]};
            if (t >= {1'b0, r_div}) begin
                n_rem[a]  = CNT_W'(t - {1'b0, r_div});
                n_work[a] = {r_work[a][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[a]  = t[CNT_W-1:0];
                n_work[a] = {r_work[a][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_step <= '0;
                r_div  <= i_req.divisor;
                r_work <= i_dividend;
                r_rem  <= '0;
            end else if (r_run) begin
                r_work <= n_work;
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for accel_batch_motion_detector: sample batches in,
// batch results checked against an in-bench shake predictor, APB threshold writes.
// Depends on abmd_pkg and the accel_batch_motion_detector RTL.
module tb;
    import abmd_pkg::*;

    localparam int REG_SPARE       = 1;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int GAP_CAP         = 40;
    localparam int SHAKE_FULL      = (1 << SHAKE_W) - 1;
    localparam int AXIS_LOW        = -(1 << (AXIS_W - 1));
    localparam int AXIS_HIGH       = (1 << (AXIS_W - 1)) - 1;

    typedef struct {
        logic [AXIS_W-1:0]  deviation;
        logic [AXIS_W-1:0]  top;
        logic [SHAKE_W-1:0] total;
        logic               dropped;
    } t_shake_report;

    class t_shake_scoreboard;
        int unsigned   threshold;
        int unsigned   stored[BATCH_MAX][AXES];
        int unsigned   sums[AXES];
        int unsigned   count;
        bit            vibration_seen;
        int unsigned   peak;
        int unsigned   shakes;
        t_shake_report reports[$];
        int            errors;

        function new();
            threshold = 32'(THRESH_RESET);
            peak = 0;
            shakes = 0;
            errors = 0;
            clear_batch();
        endfunction

        function void clear_batch();
            for (int a = 0; a < AXES; a++) sums[a] = 0;
            count = 0;
            vibration_seen = 0;
        endfunction

        function void write_reg(int index, logic [APB_DW-1:0] value);
            if (index == int'(REG_THRESH)) threshold = 32'(value[AXIS_W-1:0]);
        endfunction

        function int unsigned shift_axis(logic [AXIS_W-1:0] raw);
            int v;
            v = int'($signed(raw)) + AXIS_OFFSET;
            return (v < 0) ? 0 : v;
        endfunction

        function void note_sample(t_axes raw, bit vib, bit last, bit rst);
            int unsigned   mean[AXES];
            int unsigned   biggest;
            int unsigned   s;
            int unsigned   d;
            t_shake_report r;
            if (rst) begin
                peak = 0;
                shakes = 0;
            end
            if (vib) vibration_seen = 1;
            if (count < BATCH_MAX) begin
                for (int a = 0; a < AXES; a++) begin
                    stored[count][a] = shift_axis(raw[a]);
                    sums[a] += stored[count][a];
                end
                count++;
            end
            if (!last) return;
            if (vibration_seen || count == 0) begin
                r = '{deviation: '0, top: AXIS_W'(peak), total: SHAKE_W'(shakes),
                      dropped: 1'b1};
            end else begin
                biggest = 0;
                for (int a = 0; a < AXES; a++) mean[a] = sums[a] / count;
                for (int i = 0; i < count; i++) begin
                    for (int a = 0; a < AXES; a++) begin
                        s = stored[i][a];
                        d = (s < mean[a]) ? mean[a] - s : s - mean[a];
                        if (d > biggest) biggest = d;
                    end
                end
                biggest = biggest & ((1 << AXIS_W) - 1);
                if (biggest > peak) peak = biggest;
                if (biggest > threshold && shakes < SHAKE_FULL) shakes++;
                r = '{deviation: AXIS_W'(biggest), top: AXIS_W'(peak),
                      total: SHAKE_W'(shakes), dropped: 1'b0};
            end
            reports.push_back(r);
            clear_batch();
        endfunction

        function void match_field(string field, logic [SHAKE_W-1:0] want,
                                  logic [SHAKE_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_shake_report got);
            t_shake_report want;
            if (reports.size() == 0) begin
                $display("%0t: batch result with none expected, deviation %0d",
                         $time, got.deviation);
                errors++;
                return;
            end
            want = reports.pop_front();
            match_field("batch_deviation", SHAKE_W'(want.deviation), SHAKE_W'(got.deviation));
            match_field("running_max", SHAKE_W'(want.top), SHAKE_W'(got.top));
            match_field("shake_total", want.total, got.total);
            match_field("discarded", SHAKE_W'(want.dropped), SHAKE_W'(got.dropped));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [AXIS_W-1:0]    i_accel_x = '0;
    logic [AXIS_W-1:0]    i_accel_y = '0;
    logic [AXIS_W-1:0]    i_accel_z = '0;
    logic                 i_vibrated = 1'b0;
    logic                 i_last_sample = 1'b0;
    logic                 i_restart = 1'b0;
    logic                 o_valid;
    logic [AXIS_W-1:0]    o_batch_deviation;
    logic [AXIS_W-1:0]    o_running_max;
    logic [SHAKE_W-1:0]   o_shake_total;
    logic                 o_discarded;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    t_shake_scoreboard sb = new();
    int sender_idle = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    accel_batch_motion_detector i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_accel_x         (i_accel_x),
        .i_accel_y         (i_accel_y),
        .i_accel_z         (i_accel_z),
        .i_vibrated        (i_vibrated),
        .i_last_sample     (i_last_sample),
        .i_restart         (i_restart),
        .o_valid           (o_valid),
        .o_batch_deviation (o_batch_deviation),
        .o_running_max     (o_running_max),
        .o_shake_total     (o_shake_total),
        .o_discarded       (o_discarded),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result('{o_batch_deviation, o_running_max, o_shake_total, o_discarded});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int near(int center, int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v < AXIS_LOW) v = AXIS_LOW;
        if (v > AXIS_HIGH) v = AXIS_HIGH;
        return v;
    endfunction

    task automatic send_sample(int x, int y, int z, bit vib, bit last, bit rst);
        int gaps;
        gaps = 0;
        while (gaps < GAP_CAP && $urandom_range(99) < sender_idle) gaps++;
        @(negedge i_clk);
        if (gaps > 0) begin
            start <= 1'b0;
            repeat (gaps) @(negedge i_clk);
        end
        i_accel_x     <= AXIS_W'(x);
        i_accel_y     <= AXIS_W'(y);
        i_accel_z     <= AXIS_W'(z);
        i_vibrated    <= vib;
        i_last_sample <= last;
        i_restart     <= rst;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_sample(t_axes'({AXIS_W'(z), AXIS_W'(y), AXIS_W'(x)}), vib, last, rst);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic apb_write(int index, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * index);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(index, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_batch();
        int len;
        int pick;
        int spread;
        int vib_at;
        int center[AXES];
        pick = $urandom_range(99);
        if (pick < 45) len = $urandom_range(4, 2);
        else if (pick < 80) len = $urandom_range(10, 5);
        else if (pick < 86) len = 1;
        else if (pick < 93) len = $urandom_range(20, 11);
        else len = $urandom_range(40, 28);
        case ($urandom_range(3))
            0: spread = 20;
            1: spread = 600;
            2: spread = 1500;
            default: spread = 4096;
        endcase
        for (int a = 0; a < AXES; a++) center[a] = int'($urandom_range(8191)) + AXIS_LOW;
        vib_at = -1;
        if ($urandom_range(99) < 12) vib_at = $urandom_range(len - 1);
        for (int i = 0; i < len; i++) begin
            send_sample(near(center[0], spread), near(center[1], spread),
                        near(center[2], spread),
                        i == vib_at || $urandom_range(199) == 0,
                        i == len - 1, $urandom_range(99) < 4);
        end
    endtask

    int unsigned phase_limit[5];
    int          phase_idle[5] = '{0, 71, 22, 0, 0};
    int          phase_start;

    initial begin
        phase_limit = '{0, 8191, $urandom_range(1500, 300), 1000, $urandom_range(8191)};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_sample(AXIS_LOW, AXIS_HIGH, 0, 0, 1, 0);
        send_sample(AXIS_LOW, AXIS_LOW, AXIS_LOW, 0, 0, 0);
        send_sample(AXIS_HIGH, AXIS_HIGH, AXIS_HIGH, 0, 1, 0);
        send_sample(-4001, -3999, -4000, 0, 0, 0);
        send_sample(-3990, 0, 5, 0, 1, 0);
        send_sample(100, -100, 7, 1, 0, 0);
        send_sample(900, -900, 70, 0, 1, 0);
        send_sample(100, 200, 300, 0, 0, 0);
        send_sample(-2000, 200, 300, 1, 1, 0);
        send_sample(10, 20, 30, 0, 0, 0);
        send_sample(500, 600, -700, 0, 1, 1);
        send_sample(1, 2, 3, 0, 0, 1);
        send_sample(2000, 2, 3, 0, 1, 0);
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(2000, 0, 0, 0, 1, 0);
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(2002, 0, 0, 0, 1, 0);
        drain_results();
        apb_write(REG_SPARE, 5);
        apb_write(int'(REG_THRESH), 0);
        send_sample(7, 7, 7, 0, 0, 0);
        send_sample(8, 7, 7, 0, 1, 0);
        send_sample(-1234, 55, 4000, 0, 1, 0);
        drain_results();
        apb_write(int'(REG_THRESH), 8191);
        send_sample(AXIS_LOW, AXIS_LOW, AXIS_LOW, 0, 0, 0);
        send_sample(AXIS_HIGH, AXIS_HIGH, AXIS_HIGH, 0, 1, 0);

        for (int i = 0; i < BATCH_MAX; i++) send_sample(near(0, 20), near(0, 20), near(0, 20),
                                                        0, 0, 0);
        send_sample(AXIS_HIGH, AXIS_HIGH, AXIS_HIGH, 0, 0, 0);
        send_sample(AXIS_HIGH, AXIS_LOW, AXIS_HIGH, 0, 1, 0);

        for (int p = 0; p < 5; p++) begin
            drain_results();
            apb_write(int'(REG_THRESH), phase_limit[p]);
            sender_idle = phase_idle[p];
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) random_batch();
        end

        drain_results();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.reports.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
